// ----- rtl/vwbp_pkg.sv -----
// Shared types and constants for the variable-width bit packer.
package vwbp_pkg;

  localparam int WORD_BITS  = 64;
  localparam int OFF_BITS   = 6;
  localparam int POS_BITS   = 15;
  localparam int WIDTH_BITS = 7;
  localparam int NEXT_BITS  = 16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR1
  } state_t;

endpackage

// ----- rtl/variable_width_bit_packer_core.sv -----
// Variable-width bit packer: LSB-first field access to a word-organized bit store.
//
// An item is taken when start is high and busy is low. It carries a command
// (write or read), a starting bit position, a field width of 1 to
// MAX_FIELD_BITS and, for a write, the value whose low bits are stored.
// Each item yields one result, shown on read_value, next_position and
// range_error for exactly one cycle while done is high; the receiver cannot
// stall, and done falls again after that cycle.
// The store is one single-port memory of 64-bit words with a registered
// read. A field touches at most two adjacent words: the accept cycle reads
// the first word, S_RD1 the second, S_RD2 writes the first word back and
// S_WR1 the second; the second word is read and written only when the field
// spans two words, and words are written back only for a write. The result
// appears in the cycle after S_WR1, the first cycle in which a new item can
// be taken, so valid items do not overlap on the single memory port.
// An item that runs past the end of the store or has a bad width is answered
// in the cycle after its accept with range_error set, and busy never rises.
// Reset clears the sequencer and the result strobe only; the store holds
// whatever it held, and a bit must be written before it is read.
module variable_width_bit_packer_core #(
  parameter int STORE_BYTES    = 4096,
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   command,
  input  logic [vwbp_pkg::POS_BITS-1:0]          bit_position,
  input  logic [vwbp_pkg::WIDTH_BITS-1:0]        field_width,
  input  logic [vwbp_pkg::WORD_BITS-1:0]         write_value,
  output logic                                   done,
  output logic [vwbp_pkg::WORD_BITS-1:0]         read_value,
  output logic [vwbp_pkg::NEXT_BITS-1:0]         next_position,
  output logic                                   range_error
);

  // The store is organized in 64-bit words; the bound is checked in bits.
  localparam int WORDS = (STORE_BYTES + 7) / 8;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned STORE_BITS = STORE_BYTES * 8;
  localparam int WB    = vwbp_pkg::WORD_BITS;

  logic [WB-1:0] mem [WORDS];
  logic [WB-1:0] rdata;

  vwbp_pkg::state_t state, state_next;

  logic          cmd_q;
  logic [5:0]    off_q;
  logic [AW-1:0] addr0_q;
  logic [vwbp_pkg::WIDTH_BITS-1:0] width_q;
  logic [WB-1:0] val_q;
  logic          span_q;
  logic [vwbp_pkg::NEXT_BITS-1:0] end_q;
  logic [WB-1:0] lo, hi;

  logic          mem_re, mem_we;
  logic [AW-1:0] mem_addr;
  logic [WB-1:0] mem_wdata;

  // Decode of the item at the ports.
  logic [vwbp_pkg::NEXT_BITS-1:0] end_in;
  logic        err_in;
  logic        accept;
  logic [7:0]  span_sum;

  assign accept   = start && !busy;
  assign end_in   = vwbp_pkg::NEXT_BITS'(bit_position)
                  + vwbp_pkg::NEXT_BITS'(field_width);
  assign err_in   = (field_width == '0)
                 || (32'(field_width) > 32'(MAX_FIELD_BITS))
                 || (32'(end_in) > STORE_BITS);
  assign span_sum = 8'(bit_position[vwbp_pkg::OFF_BITS-1:0]) + 8'(field_width);

  // Field mask and the two-word merge and extract.
  logic [WB-1:0]   fmask;
  logic [2*WB-1:0] pair, mask_sh, data_sh, merged, extract;

  assign fmask   = (32'(width_q) >= WB) ? '1
                 : ((WB'(1) << width_q) - WB'(1));
  assign pair    = {hi, lo};
  assign mask_sh = {{WB{1'b0}}, fmask} << off_q;
  assign data_sh = {{WB{1'b0}}, val_q & fmask} << off_q;
  assign merged  = (pair & ~mask_sh) | data_sh;
  assign extract = pair >> off_q;

  assign busy = (state != vwbp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vwbp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: read the field's words, then write them back (writes only for a write).
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = addr0_q;
    mem_wdata  = merged[WB-1:0];
    unique case (state)
      vwbp_pkg::S_IDLE: begin
        mem_addr = AW'(bit_position[vwbp_pkg::POS_BITS-1:vwbp_pkg::OFF_BITS]);
        if (accept && !err_in) begin
          mem_re     = 1'b1;
          state_next = vwbp_pkg::S_RD1;
        end
      end
      vwbp_pkg::S_RD1: begin
        mem_re     = span_q;
        mem_addr   = addr0_q + AW'(1);
        state_next = vwbp_pkg::S_RD2;
      end
      vwbp_pkg::S_RD2: begin
        mem_we     = (cmd_q == vwbp_pkg::CMD_WRITE);
        mem_addr   = addr0_q;
        mem_wdata  = merged[WB-1:0];
        state_next = vwbp_pkg::S_WR1;
      end
      vwbp_pkg::S_WR1: begin
        mem_we     = (cmd_q == vwbp_pkg::CMD_WRITE) && span_q;
        mem_addr   = addr0_q + AW'(1);
        mem_wdata  = merged[2*WB-1:WB];
        state_next = vwbp_pkg::S_IDLE;
      end
      default: begin
        state_next = vwbp_pkg::S_IDLE;
      end
    endcase
  end

  // Word store with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // Item registers and the two fetched words.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      off_q   <= bit_position[vwbp_pkg::OFF_BITS-1:0];
      addr0_q <= AW'(bit_position[vwbp_pkg::POS_BITS-1:vwbp_pkg::OFF_BITS]);
      width_q <= field_width;
      val_q   <= write_value;
      span_q  <= (span_sum > 8'(WB));
      end_q   <= end_in;
    end
    if (state == vwbp_pkg::S_RD1) begin
      lo <= rdata;
    end
    if (state == vwbp_pkg::S_RD2) begin
      hi <= rdata;
    end
  end

  // Result registers: a rejected item answers at once, a valid one after S_WR1.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && err_in) || (state == vwbp_pkg::S_WR1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && err_in) begin
      read_value    <= '0;
      next_position <= vwbp_pkg::NEXT_BITS'(bit_position);
      range_error   <= 1'b1;
    end else if (state == vwbp_pkg::S_WR1) begin
      read_value    <= (cmd_q == vwbp_pkg::CMD_READ) ? (extract[WB-1:0] & fmask) : '0;
      next_position <= end_q;
      range_error   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // An accepted item either answers next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor in progress");

  // A rejected item never returns data.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (read_value == '0))
    else $error("range error with nonzero read value");

  // The store is only written from the write-back states.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == vwbp_pkg::S_RD2) || (state == vwbp_pkg::S_WR1)))
    else $error("store written outside write-back");

  // A rejected item does not write the store while its range error is strobed out.
  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && err_in) |=> !mem_we)
    else $error("store written after a rejected item");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the variable-width bit packer core.

localparam int STORE_BYTES    = 4096;
localparam int MAX_FIELD_BITS = 64;
localparam int STORE_BITS     = STORE_BYTES * 8;

// Scoreboard: keeps its own copy of the byte store, predicts the result of every
// accepted item, and compares each result that the core strobes out.
class packer_board;
  logic [7:0]  store_bytes [STORE_BYTES];
  bit          written_bits [STORE_BITS];
  logic [63:0] exp_value [$];
  logic [15:0] exp_next [$];
  bit          exp_err [$];
  int          span_pos [$];
  int          span_width [$];
  int          errors;
  int          writes;
  int          reads;
  int          rejects;

  function new();
    errors  = 0;
    writes  = 0;
    reads   = 0;
    rejects = 0;
  endfunction

  // Work out the result of one accepted item and update the store copy.
  function void note(vwbp_pkg::command_t cmd, logic [14:0] pos, logic [6:0] width,
                     logic [63:0] value);
    int          p;
    int          w;
    int          i;
    logic [63:0] gathered;
    p = pos;
    w = width;
    gathered = '0;
    if (w == 0 || w > MAX_FIELD_BITS || p + w > STORE_BITS) begin
      // Rejected accesses leave the store alone and hold the position.
      exp_value.push_back('0);
      exp_next.push_back(p[15:0]);
      exp_err.push_back(1'b1);
      rejects++;
      return;
    end
    for (i = 0; i < w; i++) begin
      if (cmd == vwbp_pkg::CMD_WRITE) begin
        store_bytes[(p + i) / 8][(p + i) % 8] = value[i];
        written_bits[p + i] = 1'b1;
      end else begin
        gathered[i] = store_bytes[(p + i) / 8][(p + i) % 8];
      end
    end
    if (cmd == vwbp_pkg::CMD_WRITE) begin
      span_pos.push_back(p);
      span_width.push_back(w);
      writes++;
    end else begin
      reads++;
    end
    exp_value.push_back(gathered);
    exp_next.push_back(16'(p + w));
    exp_err.push_back(1'b0);
  endfunction

  // Compare one strobed result with the oldest prediction.
  function void check(logic [63:0] value, logic [15:0] next_pos, logic err);
    logic [63:0] e_value;
    logic [15:0] e_next;
    bit          e_err;
    if (exp_value.size() == 0) begin
      $display("%0t: unexpected result, read_value %h next_position %0d range_error %b",
               $time, value, next_pos, err);
      errors++;
      return;
    end
    e_value = exp_value.pop_front();
    e_next  = exp_next.pop_front();
    e_err   = exp_err.pop_front();
    if (value !== e_value) begin
      $display("%0t: read_value expected %h, got %h", $time, e_value, value);
      errors++;
    end
    if (next_pos !== e_next) begin
      $display("%0t: next_position expected %0d, got %0d", $time, e_next, next_pos);
      errors++;
    end
    if (err !== e_err) begin
      $display("%0t: range_error expected %b, got %b", $time, e_err, err);
      errors++;
    end
  endfunction

  function int pending();
    return exp_value.size();
  endfunction
endclass

module tb;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = vwbp_pkg::CMD_WRITE;
  logic [14:0] bit_position = '0;
  logic [6:0]  field_width = 7'd1;
  logic [63:0] write_value = '0;
  logic        done;
  logic [63:0] read_value;
  logic [15:0] next_position;
  logic        range_error;

  packer_board board;
  int          idle_pct [3] = '{0, 69, 8};

  variable_width_bit_packer_core #(
    .STORE_BYTES   (STORE_BYTES),
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .bit_position (bit_position),
    .field_width  (field_width),
    .write_value  (write_value),
    .done         (done),
    .read_value   (read_value),
    .next_position(next_position),
    .range_error  (range_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The core cannot be held off, so every strobed result is checked at once.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check(read_value, next_position, range_error);
    end
  end

  // Offer one item at the falling edge and hold it until the core takes it.
  // The item counts as accepted at the first rising edge with busy low.
  task automatic send_item(vwbp_pkg::command_t cmd, int pos, int width,
                           logic [63:0] value);
    @(negedge clk);
    start        <= 1'b1;
    command      <= cmd;
    bit_position <= pos[14:0];
    field_width  <= width[6:0];
    write_value  <= value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note(cmd, pos[14:0], width[6:0], value);
  endtask

  // Sender gaps: each cycle is idle with the given chance, so gap lengths are
  // geometric; every gap falls after the item before it has been accepted.
  task automatic sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start       <= 1'b0;
      write_value <= {$urandom, $urandom};
      @(posedge clk);
    end
  endtask

  // Most fields land in two small windows, at the bottom and the top of the
  // store, so they fill up quickly and random reads find written bits.
  function automatic int pick_pos(int width);
    case ($urandom_range(3))
      0, 1: return $urandom_range(1535 - width, 0);
      2: return $urandom_range(STORE_BITS - width, STORE_BITS - 1024);
      default: return $urandom_range(STORE_BITS - width, 0);
    endcase
  endfunction

  task automatic random_item();
    int                 sel;
    int                 pos;
    int                 width;
    int                 k;
    int                 j;
    int                 off;
    bit                 found;
    vwbp_pkg::command_t cmd;
    sel = $urandom_range(99);
    if (sel < 10) begin
      // Rejected access: zero width, oversized width, or running off the end.
      // A one-bit field always fits, so the last kind uses two bits or more.
      cmd = vwbp_pkg::command_t'($urandom_range(1));
      case ($urandom_range(2))
        0: begin
          width = 0;
          pos = $urandom_range(STORE_BITS - 1);
        end
        1: begin
          width = $urandom_range(127, MAX_FIELD_BITS + 1);
          pos = $urandom_range(STORE_BITS - 1);
        end
        default: begin
          width = $urandom_range(MAX_FIELD_BITS, 2);
          pos = $urandom_range(STORE_BITS - 1, STORE_BITS - width + 1);
        end
      endcase
      send_item(cmd, pos, width, {$urandom, $urandom});
    end else if (sel < 55 || board.span_pos.size() == 0) begin
      width = ($urandom_range(4) == 0) ? MAX_FIELD_BITS : $urandom_range(MAX_FIELD_BITS, 1);
      pos = pick_pos(width);
      send_item(vwbp_pkg::CMD_WRITE, pos, width, {$urandom, $urandom});
    end else begin
      // A read may only cover bits that some write has set. Try random spans
      // first; fall back to a piece of an earlier write.
      found = 1'b0;
      for (k = 0; k < 8 && !found; k++) begin
        width = $urandom_range(MAX_FIELD_BITS, 1);
        pos = pick_pos(width);
        found = 1'b1;
        for (j = 0; j < width; j++) begin
          if (!board.written_bits[pos + j]) found = 1'b0;
        end
      end
      if (!found) begin
        k = $urandom_range(board.span_pos.size() - 1);
        off = $urandom_range(board.span_width[k] - 1);
        pos = board.span_pos[k] + off;
        width = $urandom_range(board.span_width[k] - off, 1);
      end
      send_item(vwbp_pkg::CMD_READ, pos, width, {$urandom, $urandom});
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: full-width fields at both ends of the store, fields that
    // straddle a word boundary, value bits above the width that must be
    // dropped, and every kind of rejected access.
    send_item(vwbp_pkg::CMD_WRITE, 0, 64, '1);
    send_item(vwbp_pkg::CMD_READ, 0, 64, '0);
    send_item(vwbp_pkg::CMD_WRITE, 0, 1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(vwbp_pkg::CMD_READ, 0, 8, '1);
    send_item(vwbp_pkg::CMD_WRITE, 60, 64, 64'hA5A5_5A5A_0F0F_F0F0);
    send_item(vwbp_pkg::CMD_READ, 60, 64, '0);
    send_item(vwbp_pkg::CMD_READ, 63, 2, '0);
    send_item(vwbp_pkg::CMD_WRITE, STORE_BITS - 64, 64, 64'h8000_0000_0000_0001);
    send_item(vwbp_pkg::CMD_READ, STORE_BITS - 64, 64, '0);
    send_item(vwbp_pkg::CMD_WRITE, STORE_BITS - 1, 1, 64'h1);
    send_item(vwbp_pkg::CMD_READ, STORE_BITS - 1, 1, '0);
    send_item(vwbp_pkg::CMD_WRITE, STORE_BITS - 63, 64, '0);
    send_item(vwbp_pkg::CMD_READ, STORE_BITS - 1, 2, '0);
    send_item(vwbp_pkg::CMD_WRITE, 100, 0, '1);
    send_item(vwbp_pkg::CMD_READ, 0, 65, '0);
    send_item(vwbp_pkg::CMD_WRITE, 0, 127, '0);
    send_item(vwbp_pkg::CMD_READ, STORE_BITS - 1, 127, '0);
    send_item(vwbp_pkg::CMD_READ, STORE_BITS - 64, 64, '0);
    send_item(vwbp_pkg::CMD_WRITE, 5, 3, 64'h7);
    send_item(vwbp_pkg::CMD_READ, 0, 16, '0);
    send_item(vwbp_pkg::CMD_WRITE, 64, 64, '0);
    send_item(vwbp_pkg::CMD_READ, 32, 64, '0);

    // Random part in three pacing phases: back to back, a mostly idle sender,
    // and a sender that pauses now and then.
    for (int phase = 0; phase < 3; phase++) begin
      repeat (550) begin
        sender_gap(idle_pct[phase]);
        random_item();
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d writes, %0d reads and %0d rejected accesses,",
             board.writes, board.reads, board.rejects);
    $display("sent back to back and with sparse and frequent sender gaps.");
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vwbp_pkg.sv
rtl/variable_width_bit_packer_core.sv
sim/tb.sv
